[rtl/owtm_pkg.sv]
// Shared types, constants and helpers for the one-wire temperature master.
package owtm_pkg;

    // Timer width and saturation value
    localparam int CW = 20;
    localparam logic [CW-1:0] CMAX = '1;
    localparam int DURW = 20;                       // widest duration register
    localparam int XW = (CW > DURW) ? CW : DURW;    // width used for timer compares

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WR1_LOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RD_LOW     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RD_SAMPLE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CONV_WAIT  = 3'd6;

    typedef struct packed {
        logic [9:0]  reset_low_ticks;
        logic [7:0]  presence_sample_ticks;
        logic [7:0]  slot_ticks;
        logic [5:0]  write_one_low_ticks;
        logic [5:0]  read_low_ticks;
        logic [5:0]  read_sample_ticks;
        logic [19:0] conversion_wait_ticks;
    } t_cfg;

    // Sequence steps
    localparam logic [3:0] STEP_RST_PRESENCE = 4'd0;
    localparam logic [3:0] STEP_RST_CONVERT  = 4'd1;
    localparam logic [3:0] STEP_SKIP_A       = 4'd2;
    localparam logic [3:0] STEP_CMD_CONVERT  = 4'd3;
    localparam logic [3:0] STEP_CONV_WAIT    = 4'd4;
    localparam logic [3:0] STEP_RST_READ     = 4'd5;
    localparam logic [3:0] STEP_SKIP_B       = 4'd6;
    localparam logic [3:0] STEP_CMD_READ     = 4'd7;
    localparam logic [3:0] STEP_READ_LO      = 4'd8;
    localparam logic [3:0] STEP_READ_HI      = 4'd9;
    localparam logic [3:0] STEP_FINISH       = 4'd10;

    // ROM/function commands
    localparam logic [7:0] CMD_SKIP_ROM  = 8'hCC;
    localparam logic [7:0] CMD_CONVERT   = 8'h44;
    localparam logic [7:0] CMD_READ_SCR  = 8'hBE;

    localparam logic [2:0] LAST_BIT = 3'd7;

    typedef enum logic [11:0] {
        PH_IDLE      = 12'b0000_0000_0001,
        PH_RST_LOW   = 12'b0000_0000_0010,
        PH_RST_WAIT  = 12'b0000_0000_0100,
        PH_RST_REC   = 12'b0000_0000_1000,
        PH_WR_LOW    = 12'b0000_0001_0000,
        PH_WR_HIGH   = 12'b0000_0010_0000,
        PH_RD_LOW    = 12'b0000_0100_0000,
        PH_RD_WAIT   = 12'b0000_1000_0000,
        PH_RD_TAIL   = 12'b0001_0000_0000,
        PH_CONV      = 12'b0010_0000_0000,
        PH_DONE_OK   = 12'b0100_0000_0000,
        PH_DONE_MISS = 12'b1000_0000_0000
    } t_phase;

    localparam int TEMP_W = 13;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature_f;
        logic                     device_missing;
        logic                     done_res;
        logic                     busy_res;
        logic                     drive_low;
    } t_result;

    // Fahrenheit conversion: (raw*9 + 2560) / 80, toward zero.
    // /80 = >>4 then /5; /5 as *52429 >> 18, exact for inputs below 2^18,
    // well above the range seen here.
    localparam logic signed [20:0] F_OFFSET = 21'sd2560;
    localparam logic [15:0]        RECIP5   = 16'd52429;
    localparam int                 RECIP5_SHIFT = 18;

endpackage

[rtl/owtm_temp_conv.sv]
// Registered Celsius-sixteenths to whole-Fahrenheit converter.
module owtm_temp_conv
    import owtm_pkg::*;
(
    input  logic                     i_clk,
    input  logic [15:0]              i_raw,
    output logic signed [TEMP_W-1:0] o_fahr
);

    logic signed [20:0] scaled;
    logic               neg;
    logic [19:0]        mag;
    logic [14:0]        div16;
    logic [30:0]        prod;
    logic [11:0]        quot;
    logic signed [TEMP_W-1:0] r_fahr;
    logic signed [TEMP_W-1:0] n_fahr;

    always_comb begin
        // raw*9 as shift-add, then offset
        scaled = (21'(signed'(i_raw)) <<< 3) + 21'(signed'(i_raw)) + F_OFFSET;
        neg    = scaled[20];
        mag    = neg ? 20'(-scaled) : 20'(scaled);
        div16  = mag[18:4];
        prod   = 31'(div16) * 31'(RECIP5);
        quot   = prod[RECIP5_SHIFT +: 12];
        n_fahr = neg ? -signed'({1'b0, quot}) : signed'({1'b0, quot});
    end

    // registered output; read data is stable before it is shown
    always_ff @(posedge i_clk) begin
        r_fahr <= n_fahr;
    end

    assign o_fahr = r_fahr;

endmodule

[rtl/owtm_seq.sv]
// Bus sequencer: phase machine, slot timer, bit/step counters and read shifter.
module owtm_seq
    import owtm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_step,
    input  logic                     i_start,
    input  logic                     i_level,
    input  t_cfg                     i_cfg,
    input  logic signed [TEMP_W-1:0] i_fahr,
    output logic [15:0]              o_read_shift,
    output t_result                  o_result
);

    t_phase      r_phase, n_phase;
    logic [CW-1:0] r_tick, n_tick;
    logic [2:0]  r_bit, n_bit;
    logic [3:0]  r_step, n_step;
    logic [15:0] r_shift, n_shift;
    logic        r_absent, n_absent;

    logic [7:0]    cmd_byte;
    logic          out_bit;
    logic [DURW-1:0] dur;
    logic [XW-1:0] dur_x;
    logic [XW-1:0] dur_clip;
    logic [CW-1:0] tick_inc;
    logic          over;
    logic [CW-1:0] tick_nxt;
    logic          adv_bit;
    logic          adv_unit;
    logic [3:0]    step_inc;

    function automatic t_phase unit_phase(input logic [3:0] s);
        t_phase p;
        case (s) inside
            STEP_RST_PRESENCE, STEP_RST_CONVERT, STEP_RST_READ: p = PH_RST_LOW;
            STEP_SKIP_A, STEP_CMD_CONVERT, STEP_SKIP_B, STEP_CMD_READ: p = PH_WR_LOW;
            STEP_CONV_WAIT:                                     p = PH_CONV;
            STEP_READ_LO, STEP_READ_HI:                         p = PH_RD_LOW;
            STEP_FINISH:                                        p = PH_DONE_OK;
            default:                                            p = PH_IDLE;
        endcase
        return p;
    endfunction

    always_comb begin
        case (r_step)
            STEP_CMD_CONVERT: cmd_byte = CMD_CONVERT;
            STEP_CMD_READ:    cmd_byte = CMD_READ_SCR;
            default:          cmd_byte = CMD_SKIP_ROM;
        endcase
        out_bit = cmd_byte[r_bit];
    end

    // duration of the current phase
    always_comb begin
        case (r_phase)
            PH_RST_LOW, PH_RST_REC: dur = DURW'(i_cfg.reset_low_ticks);
            PH_RST_WAIT:            dur = DURW'(i_cfg.presence_sample_ticks);
            PH_WR_LOW:              dur = out_bit ? DURW'(i_cfg.write_one_low_ticks)
                                                  : DURW'(i_cfg.slot_ticks);
            PH_WR_HIGH, PH_RD_TAIL: dur = DURW'(i_cfg.slot_ticks);
            PH_RD_LOW:              dur = DURW'(i_cfg.read_low_ticks);
            PH_RD_WAIT:             dur = DURW'(i_cfg.read_sample_ticks);
            PH_CONV:                dur = i_cfg.conversion_wait_ticks;
            default:                dur = '0;
        endcase
        dur_x    = XW'(dur);
        dur_clip = (dur_x > XW'(CMAX)) ? XW'(CMAX) : dur_x;
        tick_inc = (r_tick == CMAX) ? r_tick : CW'(r_tick + 1'b1);
        over     = XW'(tick_inc) >= dur_clip;
        tick_nxt = over ? '0 : tick_inc;
    end

    always_comb begin
        n_phase  = r_phase;
        n_tick   = r_tick;
        n_bit    = r_bit;
        n_step   = r_step;
        n_shift  = r_shift;
        n_absent = r_absent;
        adv_bit  = 1'b0;
        adv_unit = 1'b0;
        step_inc = 4'(r_step + 1'b1);

        case (r_phase)
            PH_IDLE: begin
                if (i_start) begin
                    n_step   = STEP_RST_PRESENCE;
                    n_shift  = '0;
                    n_absent = 1'b0;
                    n_tick   = '0;
                    n_bit    = '0;
                    n_phase  = unit_phase(STEP_RST_PRESENCE);
                end
            end
            PH_RST_LOW: begin
                n_tick = tick_nxt;
                if (over) n_phase = PH_RST_WAIT;
            end
            PH_RST_WAIT: begin
                n_tick = tick_nxt;
                if (over) begin
                    if (r_step == STEP_RST_PRESENCE) n_absent = i_level;
                    n_phase = PH_RST_REC;
                end
            end
            PH_RST_REC: begin
                n_tick = tick_nxt;
                if (over) begin
                    if (r_step == STEP_RST_PRESENCE && r_absent) begin
                        n_phase = PH_DONE_MISS;
                    end else begin
                        adv_unit = 1'b1;
                    end
                end
            end
            PH_WR_LOW: begin
                n_tick = tick_nxt;
                if (over) begin
                    if (out_bit) n_phase = PH_WR_HIGH;
                    else         adv_bit = 1'b1;
                end
            end
            PH_WR_HIGH, PH_RD_TAIL: begin
                n_tick = tick_nxt;
                if (over) adv_bit = 1'b1;
            end
            PH_RD_LOW: begin
                n_tick = tick_nxt;
                if (over) n_phase = PH_RD_WAIT;
            end
            PH_RD_WAIT: begin
                n_tick = tick_nxt;
                if (over) begin
                    if (i_level) n_shift[{r_step == STEP_READ_HI, r_bit}] = 1'b1;
                    n_phase = PH_RD_TAIL;
                end
            end
            PH_CONV: begin
                n_tick = tick_nxt;
                if (over) adv_unit = 1'b1;
            end
            default: begin
                // done phases return to idle
                n_phase = PH_IDLE;
                n_tick  = '0;
                n_step  = '0;
                n_bit   = '0;
            end
        endcase

        if (adv_bit) begin
            if (r_bit >= LAST_BIT) begin
                adv_unit = 1'b1;
            end else begin
                n_bit   = 3'(r_bit + 1'b1);
                n_phase = (r_phase == PH_WR_LOW || r_phase == PH_WR_HIGH) ? PH_WR_LOW
                                                                          : PH_RD_LOW;
            end
        end

        if (adv_unit) begin
            n_step  = step_inc;
            n_phase = unit_phase(step_inc);
            n_tick  = '0;
            n_bit   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_tick   <= '0;
            r_bit    <= '0;
            r_step   <= '0;
            r_shift  <= '0;
            r_absent <= 1'b0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_tick   <= n_tick;
            r_bit    <= n_bit;
            r_step   <= n_step;
            r_shift  <= n_shift;
            r_absent <= n_absent;
        end
    end

    assign o_read_shift = r_shift;

    always_comb begin
        o_result.drive_low      = (r_phase == PH_RST_LOW) || (r_phase == PH_WR_LOW)
                                  || (r_phase == PH_RD_LOW);
        o_result.busy_res       = (r_phase != PH_IDLE) && (r_phase != PH_DONE_OK)
                                  && (r_phase != PH_DONE_MISS);
        o_result.done_res       = (r_phase == PH_DONE_OK) || (r_phase == PH_DONE_MISS);
        o_result.device_missing = (r_phase == PH_DONE_MISS);
        o_result.temperature_f  = (r_phase == PH_DONE_OK) ? i_fahr : '0;
    end

endmodule

[rtl/one_wire_temperature_master_top.sv]
// One-wire temperature master: config registers, sequencer, converter, output stage.
//
// Each input beat is one microsecond tick carrying a start request (bit 0) and the
// sampled bus level (bit 1); each tick yields exactly one output beat with the bus
// pull-low drive, busy, done, missing-device flag and the temperature in whole
// degrees Fahrenheit (nonzero only on a successful done beat). A start is taken only
// when idle and runs: reset with presence check, reset + skip-ROM + convert, the
// conversion wait, reset + skip-ROM + read-scratchpad, and a two-byte read. The
// block takes one tick per clock cycle unless the sink stalls the output, and a
// registered output stage lets the next tick enter in the same cycle that the
// sink takes the previous result. Output beat fields reflect the phase at the
// start of the tick. Timing registers are to be written through the plain write
// port while no measurement runs, not enforced by the block; zero acts as one tick.
module one_wire_temperature_master_top
    import owtm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // tick stream in
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [7:0]            i_s_axis_tdata,   // [0] start_req, [1] bus_level
    // result stream out
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [23:0]           o_m_axis_tdata,   // [0] drive_low, [1] busy_res,
                                                    // [2] done_res, [3] device_missing,
                                                    // [16:4] temperature_f
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg        r_cfg;
    logic        step;
    logic [15:0] read_shift;
    logic signed [TEMP_W-1:0] fahr;
    t_result     result;
    logic        r_m_valid;
    logic [23:0] r_m_data;

    // Timing registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low_ticks       <= 10'd480;
            r_cfg.presence_sample_ticks <= 8'd60;
            r_cfg.slot_ticks            <= 8'd60;
            r_cfg.write_one_low_ticks   <= 6'd1;
            r_cfg.read_low_ticks        <= 6'd2;
            r_cfg.read_sample_ticks     <= 6'd5;
            r_cfg.conversion_wait_ticks <= 20'd1000000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RESET_LOW: r_cfg.reset_low_ticks       <= i_cfg_data[9:0];
                CFG_PRESENCE:  r_cfg.presence_sample_ticks <= i_cfg_data[7:0];
                CFG_SLOT:      r_cfg.slot_ticks            <= i_cfg_data[7:0];
                CFG_WR1_LOW:   r_cfg.write_one_low_ticks   <= i_cfg_data[5:0];
                CFG_RD_LOW:    r_cfg.read_low_ticks        <= i_cfg_data[5:0];
                CFG_RD_SAMPLE: r_cfg.read_sample_ticks     <= i_cfg_data[5:0];
                CFG_CONV_WAIT: r_cfg.conversion_wait_ticks <= i_cfg_data[19:0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    // a tick enters whenever the output slot is free or draining this cycle
    assign o_s_axis_tready = !r_m_valid || i_m_axis_tready;
    assign step            = i_s_axis_tvalid && o_s_axis_tready;

    owtm_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_start      (i_s_axis_tdata[0]),
        .i_level      (i_s_axis_tdata[1]),
        .i_cfg        (r_cfg),
        .i_fahr       (fahr),
        .o_read_shift (read_shift),
        .o_result     (result)
    );

    owtm_temp_conv u_conv (
        .i_clk  (i_clk),
        .i_raw  (read_shift),
        .o_fahr (fahr)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (step) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_m_data <= {7'd0, result};
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

endmodule

[rtl/owtm_checker.sv]
// Port-level checks for the one-wire temperature master, bound to the top level.
module owtm_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    input  logic [23:0]           o_m_axis_tdata
);

    // no result beat right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result beat valid after reset");

    // stalled result beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result beat changed");

    // the bus is only pulled low while a measurement runs
    a_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[0] |-> o_m_axis_tdata[1])
        else $error("bus driven low while not busy");

    // missing flag and temperature appear only on a done beat
    a_done_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[3] || o_m_axis_tdata[16:4] != '0)
        |-> o_m_axis_tdata[2] && !o_m_axis_tdata[1])
        else $error("done-only fields outside a done beat");

    // a missing device never reports a temperature
    a_missing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[3] |-> o_m_axis_tdata[16:4] == '0)
        else $error("temperature reported with device missing");

endmodule

bind one_wire_temperature_master_top owtm_checker u_owtm_checker (.*);
